// ----- rtl/spbc_pkg.sv -----
// shared types and constants of the smooth polyline bezier control block
`timescale 1ns / 1ps

package spbc_pkg;

   localparam int OP_W = 5;

   localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
   localparam logic [OP_W-1:0] OP_LATCH     = 5'd1;
   localparam logic [OP_W-1:0] OP_LOAD_A    = 5'd2;
   localparam logic [OP_W-1:0] OP_LOAD_B    = 5'd3;
   localparam logic [OP_W-1:0] OP_DIFF      = 5'd4;
   localparam logic [OP_W-1:0] OP_SQX       = 5'd5;
   localparam logic [OP_W-1:0] OP_SQY       = 5'd6;
   localparam logic [OP_W-1:0] OP_SQRT_STEP = 5'd7;
   localparam logic [OP_W-1:0] OP_LEN_SAVE  = 5'd8;
   localparam logic [OP_W-1:0] OP_DIV_INIT  = 5'd9;
   localparam logic [OP_W-1:0] OP_DIV_STEP  = 5'd10;
   localparam logic [OP_W-1:0] OP_DIV_SAVE  = 5'd11;
   localparam logic [OP_W-1:0] OP_PULL_SR   = 5'd12;
   localparam logic [OP_W-1:0] OP_PULL_MUL  = 5'd13;
   localparam logic [OP_W-1:0] OP_PULL_SAT  = 5'd14;
   localparam logic [OP_W-1:0] OP_EMIT_MOVE = 5'd15;
   localparam logic [OP_W-1:0] OP_EMIT_SEG  = 5'd16;
   localparam logic [OP_W-1:0] OP_COMMIT    = 5'd17;

   localparam int ITER_W    = 6;
   localparam int DIV_STEPS = 17;
   localparam int SMOOTH_W  = 17;
   localparam int WEIGHT_W  = 17;

   localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 17'd39322;
   localparam logic [WEIGHT_W-1:0] ONE_Q16      = 17'd65536;

   localparam logic [1:0] KIND_MOVE  = 2'd0;
   localparam logic [1:0] KIND_CUBIC = 2'd1;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      sel;
      logic            run_last;
      logic            curve_last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] seen;
      logic       curve_end;
      logic       out_free;
      logic       iter_last;
   } status_type;

endpackage

// ----- rtl/spbc_if.sv -----
// point and result channel interfaces
`timescale 1ns / 1ps

interface spbc_req_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          curve_end;

   modport source(output valid, output point_x, output point_y, output curve_end,
                  input ready);
   modport sink(input valid, input point_x, input point_y, input curve_end,
                output ready);
endinterface

interface spbc_rsp_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic signed [COORD_WIDTH-1:0] first_ctrl_x;
   logic signed [COORD_WIDTH-1:0] first_ctrl_y;
   logic signed [COORD_WIDTH-1:0] second_ctrl_x;
   logic signed [COORD_WIDTH-1:0] second_ctrl_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;
   logic                          run_last;
   logic                          curve_last;

   modport source(output valid, output kind, output first_ctrl_x, output first_ctrl_y,
                  output second_ctrl_x, output second_ctrl_y, output end_x,
                  output end_y, output run_last, output curve_last, input ready);
   modport sink(input valid, input kind, input first_ctrl_x, input first_ctrl_y,
                input second_ctrl_x, input second_ctrl_y, input end_x,
                input end_y, input run_last, input curve_last, output ready);
endinterface

// ----- rtl/spbc_ctrl.sv -----
// sequencer state machine for the bezier control datapath
`timescale 1ns / 1ps

module spbc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  spbc_pkg::status_type status,
   output spbc_pkg::cmd_type    cmd
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_PLAN   = 5'd1;
   localparam logic [4:0] S_MOVE   = 5'd2;
   localparam logic [4:0] S_LOADA  = 5'd3;
   localparam logic [4:0] S_LOADB  = 5'd4;
   localparam logic [4:0] S_DIFF   = 5'd5;
   localparam logic [4:0] S_SQX    = 5'd6;
   localparam logic [4:0] S_SQY    = 5'd7;
   localparam logic [4:0] S_SQRT   = 5'd8;
   localparam logic [4:0] S_LSAVE  = 5'd9;
   localparam logic [4:0] S_DIVI   = 5'd10;
   localparam logic [4:0] S_DIV    = 5'd11;
   localparam logic [4:0] S_DSAVE  = 5'd12;
   localparam logic [4:0] S_PSR    = 5'd13;
   localparam logic [4:0] S_PMUL   = 5'd14;
   localparam logic [4:0] S_PSAT   = 5'd15;
   localparam logic [4:0] S_EMIT   = 5'd16;
   localparam logic [4:0] S_COMMIT = 5'd17;

   logic [4:0] state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic       do_b_ff, do_b_in;
   logic       cur_a_ff, cur_a_in;
   logic       more;

   assign req_ready = (state_ff == S_IDLE);
   assign more      = cur_a_ff && do_b_ff;

   always_comb begin
      state_in       = state_ff;
      k_in           = k_ff;
      do_b_in        = do_b_ff;
      cur_a_in       = cur_a_ff;
      cmd.op         = spbc_pkg::OP_NONE;
      cmd.sel        = k_ff;
      cmd.run_last   = 1'b0;
      cmd.curve_last = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = spbc_pkg::OP_LATCH;
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            do_b_in = status.curve_end && (status.seen != 2'd0);
            if (status.seen == 2'd0) begin
               state_in = S_MOVE;
            end else if (status.seen inside {2'd2, 2'd3}) begin
               state_in = S_LOADA;
            end else if (status.curve_end) begin
               state_in = S_LOADB;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_MOVE: begin
            if (status.out_free) begin
               cmd.op         = spbc_pkg::OP_EMIT_MOVE;
               cmd.run_last   = 1'b1;
               cmd.curve_last = status.curve_end;
               state_in       = S_COMMIT;
            end
         end
         S_LOADA: begin
            cmd.op   = spbc_pkg::OP_LOAD_A;
            cur_a_in = 1'b1;
            k_in     = 2'd0;
            state_in = S_DIFF;
         end
         S_LOADB: begin
            cmd.op   = spbc_pkg::OP_LOAD_B;
            cur_a_in = 1'b0;
            k_in     = 2'd0;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.op   = spbc_pkg::OP_DIFF;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd.op   = spbc_pkg::OP_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = spbc_pkg::OP_SQY;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = spbc_pkg::OP_SQRT_STEP;
            if (status.iter_last) begin
               state_in = S_LSAVE;
            end
         end
         S_LSAVE: begin
            cmd.op = spbc_pkg::OP_LEN_SAVE;
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = S_DIVI;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_DIFF;
            end
         end
         S_DIVI: begin
            cmd.op   = spbc_pkg::OP_DIV_INIT;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = spbc_pkg::OP_DIV_STEP;
            if (status.iter_last) begin
               state_in = S_DSAVE;
            end
         end
         S_DSAVE: begin
            cmd.op = spbc_pkg::OP_DIV_SAVE;
            if (k_ff == 2'd1) begin
               k_in     = 2'd0;
               state_in = S_PSR;
            end else begin
               k_in     = 2'd1;
               state_in = S_DIVI;
            end
         end
         S_PSR: begin
            cmd.op   = spbc_pkg::OP_PULL_SR;
            state_in = S_PMUL;
         end
         S_PMUL: begin
            cmd.op   = spbc_pkg::OP_PULL_MUL;
            state_in = S_PSAT;
         end
         S_PSAT: begin
            cmd.op = spbc_pkg::OP_PULL_SAT;
            if (k_ff == 2'd3) begin
               k_in     = 2'd0;
               state_in = S_EMIT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_PSR;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.op         = spbc_pkg::OP_EMIT_SEG;
               cmd.run_last   = !more;
               cmd.curve_last = !more && status.curve_end;
               state_in       = more ? S_LOADB : S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.op   = spbc_pkg::OP_COMMIT;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= 2'd0;
         do_b_ff  <= 1'b0;
         cur_a_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         do_b_ff  <= do_b_in;
         cur_a_ff <= cur_a_in;
      end
   end

endmodule

// ----- rtl/spbc_dp.sv -----
// datapath: point window, length, ratio and pull units, result register
`timescale 1ns / 1ps

module spbc_dp #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [COORD_WIDTH-1:0]       in_point_x,
   input  logic signed [COORD_WIDTH-1:0]       in_point_y,
   input  logic                                in_curve_end,
   input  logic                                csr_write_enable,
   input  logic [spbc_pkg::SMOOTH_W-1:0]       csr_write_data,
   input  spbc_pkg::cmd_type                   cmd,
   output spbc_pkg::status_type                status,
   spbc_rsp_if.source                          rsp
);

   localparam int W         = COORD_WIDTH;
   localparam int LEN_SHIFT = (W > 31) ? W - 31 : 0;
   localparam int DW        = W - LEN_SHIFT;
   localparam int SQ_W      = 2 * DW + 2;
   localparam int LW        = DW + 1;
   localparam int SW        = LW + 1;
   localparam int WW        = spbc_pkg::WEIGHT_W;

   localparam logic signed [W+2:0] CMAX = {4'b0000, {(W-1){1'b1}}};
   localparam logic signed [W+2:0] CMIN = {4'b1111, {(W-1){1'b0}}};

   function automatic logic [W:0] abs_diff(input logic signed [W-1:0] a,
                                           input logic signed [W-1:0] b);
      logic [W:0] d;
      logic [W:0] mg;
      d  = {a[W-1], a} - {b[W-1], b};
      mg = d[W] ? (~d + 1'b1) : d;
      return {d[W], mg[W-1:0]};
   endfunction

   logic [spbc_pkg::SMOOTH_W-1:0] smooth_ff;

   logic signed [W-1:0] win_x_ff [3];
   logic signed [W-1:0] win_y_ff [3];
   logic [1:0]          seen_ff;
   logic signed [W-1:0] in_x_ff, in_y_ff;
   logic                end_ff;

   logic signed [W-1:0] px_ff [4];
   logic signed [W-1:0] py_ff [4];

   logic [DW-1:0]       dx_ff, dy_ff;
   logic [2*DW-1:0]     sqx_ff;
   logic [SQ_W-1:0]     sq_v_ff, sq_r_ff, sq_b_ff;
   logic [LW-1:0]       len_ff [3];
   logic [spbc_pkg::ITER_W-1:0] iter_ff;

   logic [SW:0]         rem_ff;
   logic [SW-1:0]       den_ff;
   logic [WW-1:0]       q_ff;
   logic                dz_ff, first_ff;
   logic [WW-1:0]       w0_ff, w1_ff;

   logic [WW-1:0]       sr_ff;
   logic [W-1:0]        m_ff;
   logic                neg_ff;
   logic signed [W-1:0] base_ff;
   logic [W:0]          a_ff;
   logic [WW-1:0]       c_ff;
   logic signed [W-1:0] ctrl_ff [4];

   logic                rsp_valid_ff;
   logic                kind_ff, run_last_ff, curve_last_ff;
   logic signed [W-1:0] o_c_ff [4];
   logic signed [W-1:0] o_ex_ff, o_ey_ff;

   // combinational helpers
   logic [W:0]          ad_x, ad_y, ad_p;
   logic [SQ_W:0]       sq_rb;
   logic [SW-1:0]       den_c;
   logic [SW:0]         div_t;
   logic [WW-1:0]       s_c, w_sel, k_c;
   logic [2*WW-1:0]     sw_prod;
   logic signed [W-1:0] p_base, p_from, p_to;
   logic [W+15:0]       m_ext;
   logic [W+WW-1:0]     hi_prod;
   logic [32:0]         lo_prod;
   logic [17:0]         half_t;
   logic [W:0]          q_c;
   logic signed [W+2:0] sum_c;
   logic signed [W-1:0] sat_c;
   logic [LW-1:0]       len_hi;

   assign ad_x = abs_diff(px_ff[cmd.sel + 2'd1], px_ff[cmd.sel]);
   assign ad_y = abs_diff(py_ff[cmd.sel + 2'd1], py_ff[cmd.sel]);
   assign sq_rb = {1'b0, sq_r_ff} + {1'b0, sq_b_ff};

   assign len_hi = cmd.sel[0] ? len_ff[2] : len_ff[1];
   assign den_c  = {1'b0, len_ff[cmd.sel]} + {1'b0, len_hi};
   assign div_t  = first_ff ? rem_ff : {rem_ff[SW-1:0], 1'b0};
   assign k_c    = dz_ff ? '0 : q_ff;

   assign s_c     = (smooth_ff > spbc_pkg::ONE_Q16) ? spbc_pkg::ONE_Q16 : smooth_ff;
   assign w_sel   = cmd.sel[1] ? w1_ff : w0_ff;
   assign sw_prod = s_c * w_sel;

   always_comb begin
      case (cmd.sel)
         2'd0: begin
            p_base = px_ff[1]; p_from = px_ff[0]; p_to = px_ff[2];
         end
         2'd1: begin
            p_base = py_ff[1]; p_from = py_ff[0]; p_to = py_ff[2];
         end
         2'd2: begin
            p_base = px_ff[2]; p_from = px_ff[3]; p_to = px_ff[1];
         end
         default: begin
            p_base = py_ff[2]; p_from = py_ff[3]; p_to = py_ff[1];
         end
      endcase
   end

   assign ad_p    = abs_diff(p_to, p_from);
   assign m_ext   = {16'b0, m_ff};
   assign hi_prod = m_ext[W+15:16] * sr_ff;
   assign lo_prod = (m_ext[15:0] * sr_ff) + 33'h10000;
   assign half_t  = {17'b0, a_ff[0]} + {1'b0, c_ff};
   assign q_c     = {1'b0, a_ff[W:1]} + {{(W-16){1'b0}}, half_t[17:1]};
   assign sum_c   = neg_ff ? ({{3{base_ff[W-1]}}, base_ff} - $signed({2'b00, q_c}))
                           : ({{3{base_ff[W-1]}}, base_ff} + $signed({2'b00, q_c}));
   assign sat_c   = (sum_c > CMAX) ? CMAX[W-1:0] :
                    (sum_c < CMIN) ? CMIN[W-1:0] : sum_c[W-1:0];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff    <= spbc_pkg::SMOOTH_RESET;
         seen_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            win_x_ff[i] <= '0;
            win_y_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            smooth_ff <= csr_write_data;
         end
         if (cmd.op == spbc_pkg::OP_EMIT_MOVE || cmd.op == spbc_pkg::OP_EMIT_SEG) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            spbc_pkg::OP_SQY:      iter_ff <= spbc_pkg::ITER_W'(DW);
            spbc_pkg::OP_DIV_INIT: iter_ff <= spbc_pkg::ITER_W'(spbc_pkg::DIV_STEPS - 1);
            spbc_pkg::OP_SQRT_STEP, spbc_pkg::OP_DIV_STEP: iter_ff <= iter_ff - 1'b1;
            spbc_pkg::OP_COMMIT: begin
               if (end_ff) begin
                  seen_ff <= 2'd0;
                  for (int i = 0; i < 3; i++) begin
                     win_x_ff[i] <= '0;
                     win_y_ff[i] <= '0;
                  end
               end else begin
                  seen_ff     <= (seen_ff == 2'd3) ? 2'd3 : seen_ff + 2'd1;
                  win_x_ff[0] <= win_x_ff[1];
                  win_y_ff[0] <= win_y_ff[1];
                  win_x_ff[1] <= win_x_ff[2];
                  win_y_ff[1] <= win_y_ff[2];
                  win_x_ff[2] <= in_x_ff;
                  win_y_ff[2] <= in_y_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // payload
   always_ff @(posedge clock) begin
      case (cmd.op)
         spbc_pkg::OP_LATCH: begin
            in_x_ff <= in_point_x;
            in_y_ff <= in_point_y;
            end_ff  <= in_curve_end;
         end
         spbc_pkg::OP_LOAD_A: begin
            px_ff[0] <= (seen_ff == 2'd3) ? win_x_ff[0] : win_x_ff[1];
            py_ff[0] <= (seen_ff == 2'd3) ? win_y_ff[0] : win_y_ff[1];
            px_ff[1] <= win_x_ff[1];
            py_ff[1] <= win_y_ff[1];
            px_ff[2] <= win_x_ff[2];
            py_ff[2] <= win_y_ff[2];
            px_ff[3] <= in_x_ff;
            py_ff[3] <= in_y_ff;
         end
         spbc_pkg::OP_LOAD_B: begin
            px_ff[0] <= (seen_ff inside {2'd2, 2'd3}) ? win_x_ff[1] : win_x_ff[2];
            py_ff[0] <= (seen_ff inside {2'd2, 2'd3}) ? win_y_ff[1] : win_y_ff[2];
            px_ff[1] <= win_x_ff[2];
            py_ff[1] <= win_y_ff[2];
            px_ff[2] <= in_x_ff;
            py_ff[2] <= in_y_ff;
            px_ff[3] <= in_x_ff;
            py_ff[3] <= in_y_ff;
         end
         spbc_pkg::OP_DIFF: begin
            dx_ff <= ad_x[W-1:LEN_SHIFT];
            dy_ff <= ad_y[W-1:LEN_SHIFT];
         end
         spbc_pkg::OP_SQX: begin
            sqx_ff <= dx_ff * dx_ff;
         end
         spbc_pkg::OP_SQY: begin
            sq_v_ff <= {2'b00, sqx_ff} + {2'b00, (2*DW)'(dy_ff * dy_ff)};
            sq_r_ff <= '0;
            sq_b_ff <= {2'b01, {(SQ_W-2){1'b0}}};
         end
         spbc_pkg::OP_SQRT_STEP: begin
            if ({1'b0, sq_v_ff} >= sq_rb) begin
               sq_v_ff <= sq_v_ff - sq_rb[SQ_W-1:0];
               sq_r_ff <= (sq_r_ff >> 1) + sq_b_ff;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
            sq_b_ff <= sq_b_ff >> 2;
         end
         spbc_pkg::OP_LEN_SAVE: begin
            len_ff[cmd.sel] <= sq_r_ff[LW-1:0];
         end
         spbc_pkg::OP_DIV_INIT: begin
            rem_ff   <= {2'b00, len_ff[cmd.sel]};
            den_ff   <= den_c;
            dz_ff    <= (den_c == '0);
            q_ff     <= '0;
            first_ff <= 1'b1;
         end
         spbc_pkg::OP_DIV_STEP: begin
            first_ff <= 1'b0;
            if (div_t >= {1'b0, den_ff}) begin
               rem_ff <= div_t - {1'b0, den_ff};
               q_ff   <= {q_ff[WW-2:0], 1'b1};
            end else begin
               rem_ff <= div_t;
               q_ff   <= {q_ff[WW-2:0], 1'b0};
            end
         end
         spbc_pkg::OP_DIV_SAVE: begin
            if (cmd.sel[0]) begin
               w1_ff <= k_c;
            end else begin
               w0_ff <= spbc_pkg::ONE_Q16 - k_c;
            end
         end
         spbc_pkg::OP_PULL_SR: begin
            sr_ff   <= sw_prod[32:16];
            m_ff    <= ad_p[W-1:0];
            neg_ff  <= ad_p[W];
            base_ff <= p_base;
         end
         spbc_pkg::OP_PULL_MUL: begin
            a_ff <= hi_prod[W:0];
            c_ff <= lo_prod[32:16];
         end
         spbc_pkg::OP_PULL_SAT: begin
            ctrl_ff[cmd.sel] <= sat_c;
         end
         spbc_pkg::OP_EMIT_MOVE: begin
            kind_ff       <= spbc_pkg::KIND_MOVE[0];
            for (int i = 0; i < 4; i++) begin
               o_c_ff[i] <= '0;
            end
            o_ex_ff       <= in_x_ff;
            o_ey_ff       <= in_y_ff;
            run_last_ff   <= cmd.run_last;
            curve_last_ff <= cmd.curve_last;
         end
         spbc_pkg::OP_EMIT_SEG: begin
            kind_ff       <= spbc_pkg::KIND_CUBIC[0];
            for (int i = 0; i < 4; i++) begin
               o_c_ff[i] <= ctrl_ff[i];
            end
            o_ex_ff       <= px_ff[2];
            o_ey_ff       <= py_ff[2];
            run_last_ff   <= cmd.run_last;
            curve_last_ff <= cmd.curve_last;
         end
         default: begin
         end
      endcase
   end

   assign status.seen      = seen_ff;
   assign status.curve_end = end_ff;
   assign status.out_free  = !rsp_valid_ff || rsp.ready;
   assign status.iter_last = (iter_ff == '0);

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kind          = kind_ff;
   assign rsp.first_ctrl_x  = o_c_ff[0];
   assign rsp.first_ctrl_y  = o_c_ff[1];
   assign rsp.second_ctrl_x = o_c_ff[2];
   assign rsp.second_ctrl_y = o_c_ff[3];
   assign rsp.end_x         = o_ex_ff;
   assign rsp.end_y         = o_ey_ff;
   assign rsp.run_last      = run_last_ff;
   assign rsp.curve_last    = curve_last_ff;

endmodule

// ----- rtl/smooth_polyline_bezier_controls_core.sv -----
// top level: smooth polyline to cubic bezier control points
// per point: a move result is registered after the plan and move states; a segment first
//   runs three square roots, two divisions and four pulls, and a closing segment runs them
//   all again; square roots and divisions run one at a time on a shared step counter
// a new point is taken only once all results of the last point have been emitted
// the next point is taken while the last result still waits in the output register
// reset: synchronous; clears window, point count, result valid; smoothing back to 0.6
`timescale 1ns / 1ps

module smooth_polyline_bezier_controls_core #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   spbc_req_if.sink                        req,
   spbc_rsp_if.source                      rsp,
   input  logic                            csr_write_enable,
   input  logic [spbc_pkg::SMOOTH_W-1:0]   csr_write_data
);

   spbc_pkg::cmd_type    cmd;
   spbc_pkg::status_type status;

   spbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   spbc_dp #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .in_point_x       (req.point_x),
      .in_point_y       (req.point_y),
      .in_curve_end     (req.curve_end),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp              (rsp)
   );

endmodule

// ----- rtl/spbc_checker.sv -----
// port level checks of the bezier control block, bound to the top level
`timescale 1ns / 1ps

module spbc_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_kind,
   input logic [COORD_WIDTH-1:0] rsp_first_ctrl_x,
   input logic [COORD_WIDTH-1:0] rsp_second_ctrl_y,
   input logic [COORD_WIDTH-1:0] rsp_end_x,
   input logic                   rsp_run_last,
   input logic                   rsp_curve_last
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_end_x) && $stable(rsp_kind))
      else $error("result changed while stalled");

   // move results carry zero control points
   a_move_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_first_ctrl_x == '0 && rsp_second_ctrl_y == '0)
      else $error("move result with nonzero control point");

   // curve end is always the last result of its point
   a_curve_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_curve_last |-> rsp_run_last)
      else $error("curve_last without run_last");

   // one point at a time
   a_one_point: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second point taken during work");

endmodule

bind smooth_polyline_bezier_controls_core spbc_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_spbc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_kind          (rsp.kind),
   .rsp_first_ctrl_x  (rsp.first_ctrl_x),
   .rsp_second_ctrl_y (rsp.second_ctrl_y),
   .rsp_end_x         (rsp.end_x),
   .rsp_run_last      (rsp.run_last),
   .rsp_curve_last    (rsp.curve_last)
);
